// ===== rtl/core/vbd_pkg.sv =====
// Shared types and constants for the volume box downscaler.
package vbd_pkg;

   // Fixed field widths.
   localparam int CFG_W   = 7;
   localparam int BIAS_W  = 9;
   localparam int TEXEL_W = 32;
   localparam int SUM_W   = 26;
   localparam int CNT_W   = 19;
   localparam int Q_W     = 8;
   localparam int REM_W   = SUM_W + 1;
   localparam int WORD_W  = 4 * SUM_W + CNT_W;
   localparam int STEP_W  = 3;

   // Index of the last quotient step for the resync lanes and the average lanes.
   localparam logic [STEP_W-1:0] SYNC_LAST_STEP = STEP_W'(CFG_W - 1);
   localparam logic [STEP_W-1:0] DIV_LAST_STEP  = STEP_W'(Q_W - 1);

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_SOURCE_WIDTH     = 3'd0;
   localparam logic [2:0] CSR_SOURCE_HEIGHT    = 3'd1;
   localparam logic [2:0] CSR_SOURCE_DEPTH     = 3'd2;
   localparam logic [2:0] CSR_SHRINK_FACTOR    = 3'd3;
   localparam logic [2:0] CSR_ALPHA_OFFSET     = 3'd4;
   localparam logic [2:0] CSR_SKIP_TRANSPARENT = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SYNC,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_item;
      logic sync_load;
      logic sync_step;
      logic sync_last;
      logic mem_read;
      logic mem_update;
      logic div_step;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sync_pending;
      logic in_range;
      logic emit_needed;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/vbd_ram.sv =====
// Generic single-clock RAM with one write port and a registered read port.
module vbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/vbd_ctrl.sv =====
// Controller state machine for the volume box downscaler.
module vbd_ctrl
   import vbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall
);

   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  ready;

   assign ready = (state_ff == ST_IDLE) && !status.sync_pending;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      step_in  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (status.sync_pending) begin
               state_in = ST_SYNC;
            end else if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_SYNC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == SYNC_LAST_STEP) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = status.in_range ? ST_UPDATE : ST_IDLE;
         end
         ST_UPDATE: begin
            state_in = status.emit_needed ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST_STEP) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = !ready;
      case (state_ff)
         ST_IDLE: begin
            cmd.sync_load = status.sync_pending;
            cmd.take_item = ready && req_valid;
         end
         ST_SYNC: begin
            cmd.sync_step = 1'b1;
            cmd.sync_last = (step_ff == SYNC_LAST_STEP);
         end
         ST_READ: begin
            cmd.mem_read = status.in_range;
         end
         ST_UPDATE: begin
            cmd.mem_update = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/core/vbd_dp.sv =====
// Datapath: configuration, position tracking, accumulator memory, dividers, output register.
module vbd_dp
   import vbd_pkg::*;
#(
   parameter int MAX_DIM = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [TEXEL_W-1:0] req_texel,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [BIAS_W-1:0]  csr_write_data,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [TEXEL_W-1:0] rsp_voxel_out,
   output logic               rsp_last_voxel
);

   localparam int PW      = $clog2(MAX_DIM);
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int AW      = $clog2(DEPTH);
   localparam int NLANE   = 6;
   localparam logic [CFG_W-1:0] MAX_DIM_C = CFG_W'(MAX_DIM);

   // Configuration registers.
   logic [CFG_W-1:0]  source_width_ff, source_height_ff, source_depth_ff, shrink_factor_ff;
   logic [BIAS_W-1:0] alpha_offset_ff;
   logic              skip_transparent_ff;
   logic              pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff     <= 7'd64;
         source_height_ff    <= 7'd64;
         source_depth_ff     <= 7'd64;
         shrink_factor_ff    <= 7'd2;
         alpha_offset_ff     <= '0;
         skip_transparent_ff <= 1'b0;
         pending_ff          <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            pending_ff <= 1'b1;
            case (csr_index)
               CSR_SOURCE_WIDTH:     source_width_ff     <= csr_write_data[CFG_W-1:0];
               CSR_SOURCE_HEIGHT:    source_height_ff    <= csr_write_data[CFG_W-1:0];
               CSR_SOURCE_DEPTH:     source_depth_ff     <= csr_write_data[CFG_W-1:0];
               CSR_SHRINK_FACTOR:    shrink_factor_ff    <= csr_write_data[CFG_W-1:0];
               CSR_ALPHA_OFFSET:     alpha_offset_ff     <= csr_write_data;
               CSR_SKIP_TRANSPARENT: skip_transparent_ff <= csr_write_data[0];
               default: ;
            endcase
         end else if (cmd.sync_load) begin
            pending_ff <= 1'b0;
         end
      end
   end

   // Effective dimensions and block edges.
   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > MAX_DIM_C) begin
         r = MAX_DIM_C;
      end
      return r;
   endfunction

   logic [CFG_W-1:0] w, h, d, s, sw, sh, sd;
   assign w  = clamp_dim(source_width_ff);
   assign h  = clamp_dim(source_height_ff);
   assign d  = clamp_dim(source_depth_ff);
   assign s  = (shrink_factor_ff == '0) ? CFG_W'(1) : shrink_factor_ff;
   assign sw = (s < w) ? s : w;
   assign sh = (s < h) ? s : h;
   assign sd = (s < d) ? s : d;

   // Resync lanes: long division of positions and dimensions by the block edges.
   logic [CFG_W-1:0] lane_dvd_ff [NLANE];
   logic [CFG_W-1:0] lane_div_ff [NLANE];
   logic [CFG_W-1:0] lane_rem_ff [NLANE];
   logic [CFG_W-1:0] lane_q_ff   [NLANE];
   logic [CFG_W-1:0] lane_rem_in [NLANE];
   logic [CFG_W-1:0] lane_q_in   [NLANE];

   // Position state.
   logic [PW-1:0]    pos_x_ff, pos_y_ff, pos_z_ff;
   logic [PW-1:0]    rx_ff, ry_ff, rz_ff, xo_ff, yo_ff, zo_ff;
   logic [CFG_W-1:0] ow_ff, oh_ff, od_ff;

   always_comb begin
      logic [CFG_W-1:0] t;
      for (int i = 0; i < NLANE; i++) begin
         t = {lane_rem_ff[i][CFG_W-2:0], lane_dvd_ff[i][CFG_W-1]};
         if (t >= lane_div_ff[i]) begin
            lane_rem_in[i] = t - lane_div_ff[i];
            lane_q_in[i]   = {lane_q_ff[i][CFG_W-2:0], 1'b1};
         end else begin
            lane_rem_in[i] = t;
            lane_q_in[i]   = {lane_q_ff[i][CFG_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sync_load) begin
         lane_dvd_ff[0] <= CFG_W'(pos_x_ff);
         lane_dvd_ff[1] <= CFG_W'(pos_y_ff);
         lane_dvd_ff[2] <= CFG_W'(pos_z_ff);
         lane_dvd_ff[3] <= w;
         lane_dvd_ff[4] <= h;
         lane_dvd_ff[5] <= d;
         lane_div_ff[0] <= sw;
         lane_div_ff[1] <= sh;
         lane_div_ff[2] <= sd;
         lane_div_ff[3] <= sw;
         lane_div_ff[4] <= sh;
         lane_div_ff[5] <= sd;
         for (int i = 0; i < NLANE; i++) begin
            lane_rem_ff[i] <= '0;
            lane_q_ff[i]   <= '0;
         end
      end else if (cmd.sync_step) begin
         for (int i = 0; i < NLANE; i++) begin
            lane_dvd_ff[i] <= lane_dvd_ff[i] << 1;
            lane_rem_ff[i] <= lane_rem_in[i];
            lane_q_ff[i]   <= lane_q_in[i];
         end
      end
   end

   // Position advance, in raster order, with block offsets tracked alongside.
   logic x_wrap, y_wrap, z_wrap;
   assign x_wrap = (CFG_W'(pos_x_ff) + 1'b1) >= w;
   assign y_wrap = (CFG_W'(pos_y_ff) + 1'b1) >= h;
   assign z_wrap = (CFG_W'(pos_z_ff) + 1'b1) >= d;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         rx_ff    <= '0;
         ry_ff    <= '0;
         rz_ff    <= '0;
         xo_ff    <= '0;
         yo_ff    <= '0;
         zo_ff    <= '0;
         ow_ff    <= '0;
         oh_ff    <= '0;
         od_ff    <= '0;
      end else if (cmd.sync_step && cmd.sync_last) begin
         rx_ff <= lane_rem_in[0][PW-1:0];
         ry_ff <= lane_rem_in[1][PW-1:0];
         rz_ff <= lane_rem_in[2][PW-1:0];
         xo_ff <= lane_q_in[0][PW-1:0];
         yo_ff <= lane_q_in[1][PW-1:0];
         zo_ff <= lane_q_in[2][PW-1:0];
         ow_ff <= lane_q_in[3];
         oh_ff <= lane_q_in[4];
         od_ff <= lane_q_in[5];
      end else if (cmd.take_item) begin
         if (!x_wrap) begin
            pos_x_ff <= pos_x_ff + 1'b1;
            if ((CFG_W'(rx_ff) + 1'b1) == sw) begin
               rx_ff <= '0;
               xo_ff <= xo_ff + 1'b1;
            end else begin
               rx_ff <= rx_ff + 1'b1;
            end
         end else begin
            pos_x_ff <= '0;
            rx_ff    <= '0;
            xo_ff    <= '0;
            if (!y_wrap) begin
               pos_y_ff <= pos_y_ff + 1'b1;
               if ((CFG_W'(ry_ff) + 1'b1) == sh) begin
                  ry_ff <= '0;
                  yo_ff <= yo_ff + 1'b1;
               end else begin
                  ry_ff <= ry_ff + 1'b1;
               end
            end else begin
               pos_y_ff <= '0;
               ry_ff    <= '0;
               yo_ff    <= '0;
               if (!z_wrap) begin
                  pos_z_ff <= pos_z_ff + 1'b1;
                  if ((CFG_W'(rz_ff) + 1'b1) == sd) begin
                     rz_ff <= '0;
                     zo_ff <= zo_ff + 1'b1;
                  end else begin
                     rz_ff <= rz_ff + 1'b1;
                  end
               end else begin
                  pos_z_ff <= '0;
                  rz_ff    <= '0;
                  zo_ff    <= '0;
               end
            end
         end
      end
   end

   // Item capture: block flags and accumulator address.
   logic               in_range_ff, first_ff, emit_ff, last_ff, use_ff;
   logic [TEXEL_W-1:0] texel_ff;
   logic [AW-1:0]      addr_ff;
   logic [PW+CFG_W-1:0] row_base;

   assign row_base = yo_ff * ow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_range_ff <= 1'b0;
         emit_ff     <= 1'b0;
      end else if (cmd.take_item) begin
         in_range_ff <= (CFG_W'(xo_ff) < ow_ff) && (CFG_W'(yo_ff) < oh_ff)
                        && (CFG_W'(zo_ff) < od_ff);
         emit_ff     <= ((CFG_W'(rx_ff) + 1'b1) == sw) && ((CFG_W'(ry_ff) + 1'b1) == sh)
                        && ((CFG_W'(rz_ff) + 1'b1) == sd);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         texel_ff <= req_texel;
         first_ff <= (rx_ff == '0) && (ry_ff == '0) && (rz_ff == '0);
         last_ff  <= ((CFG_W'(xo_ff) + 1'b1) == ow_ff) && ((CFG_W'(yo_ff) + 1'b1) == oh_ff)
                     && ((CFG_W'(zo_ff) + 1'b1) == od_ff);
         use_ff   <= (req_texel[31:24] != 8'd0) || !skip_transparent_ff;
         addr_ff  <= AW'(row_base + (PW+CFG_W)'(xo_ff));
      end
   end

   // Accumulator memory: alpha, bits 15..8, bits 23..16, bits 7..0 sums and the count.
   logic [WORD_W-1:0] rd_word, wr_word;
   logic [SUM_W-1:0]  old_sum [4];
   logic [SUM_W-1:0]  new_sum [4];
   logic [Q_W-1:0]    chan    [4];
   logic [CNT_W-1:0]  old_cnt, new_cnt;

   vbd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_update),
      .wr_addr (addr_ff),
      .wr_data (wr_word),
      .rd_en   (cmd.mem_read),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   assign chan[0] = use_ff ? texel_ff[31:24] : '0;
   assign chan[1] = use_ff ? texel_ff[15:8]  : '0;
   assign chan[2] = use_ff ? texel_ff[23:16] : '0;
   assign chan[3] = use_ff ? texel_ff[7:0]   : '0;

   // Read-modify-write; the first voxel of a block starts the sums afresh.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         old_sum[i] = first_ff ? '0 : rd_word[WORD_W-1-i*SUM_W -: SUM_W];
         new_sum[i] = old_sum[i] + SUM_W'(chan[i]);
      end
      old_cnt = first_ff ? '0 : rd_word[CNT_W-1:0];
      new_cnt = old_cnt + CNT_W'(use_ff);
      wr_word = {new_sum[0], new_sum[1], new_sum[2], new_sum[3], new_cnt};
   end

   // Average lanes: restoring division of (sum + count/2) by count, one quotient bit a step.
   logic [REM_W-1:0] avg_rem_ff [4];
   logic [REM_W-1:0] avg_dvs_ff [4];
   logic [Q_W-1:0]   avg_q_ff   [4];
   logic             cnt_zero_ff, out_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_update) begin
         cnt_zero_ff <= (new_cnt == '0);
         out_last_ff <= last_ff;
         for (int i = 0; i < 4; i++) begin
            avg_rem_ff[i] <= REM_W'(new_sum[i]) + REM_W'(new_cnt >> 1);
            avg_dvs_ff[i] <= REM_W'(new_cnt) << (Q_W - 1);
            avg_q_ff[i]   <= '0;
         end
      end else if (cmd.div_step) begin
         for (int i = 0; i < 4; i++) begin
            if (avg_rem_ff[i] >= avg_dvs_ff[i]) begin
               avg_rem_ff[i] <= avg_rem_ff[i] - avg_dvs_ff[i];
               avg_q_ff[i]   <= {avg_q_ff[i][Q_W-2:0], 1'b1};
            end else begin
               avg_q_ff[i]   <= {avg_q_ff[i][Q_W-2:0], 1'b0};
            end
            avg_dvs_ff[i] <= avg_dvs_ff[i] >> 1;
         end
      end
   end

   // Alpha bias and clamp.
   logic signed [BIAS_W+1:0] alpha_sum;
   logic [Q_W-1:0]           alpha_out;

   assign alpha_sum = $signed({3'b000, avg_q_ff[0]})
                      + $signed({{2{alpha_offset_ff[BIAS_W-1]}}, alpha_offset_ff});

   always_comb begin
      if (alpha_sum < 0) begin
         alpha_out = '0;
      end else if (alpha_sum > 255) begin
         alpha_out = 8'hFF;
      end else begin
         alpha_out = alpha_sum[Q_W-1:0];
      end
   end

   // Output register.
   logic               rsp_valid_ff;
   logic [TEXEL_W-1:0] voxel_ff;
   logic               rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         voxel_ff    <= cnt_zero_ff ? '0
                        : {alpha_out, avg_q_ff[1], avg_q_ff[2], avg_q_ff[3]};
         rsp_last_ff <= out_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_voxel_out  = voxel_ff;
   assign rsp_last_voxel = rsp_last_ff;

   // Status to the controller.
   assign status.sync_pending = pending_ff;
   assign status.in_range     = in_range_ff;
   assign status.emit_needed  = emit_ff;
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== rtl/core/volume_box_downscale_rgba.sv =====
// Top level of the streaming 3D box-filter downscaler for 32-bit voxels.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid, req_stall, req_texel         | in
//   rsp     | rsp_valid, rsp_stall, rsp_voxel_out,    | out
//           | rsp_last_voxel                          |
//   csr     | csr_write_enable, csr_index,            | in
//           | csr_write_data                          |
//
// A source voxel outside any whole block is dropped after the address and range steps; one inside
// goes through address, memory read and accumulator write-back. A voxel that completes a block
// adds the quotient steps of the four parallel restoring dividers and the output register load.
// After reset and after each configuration write, input is stalled while one step loads the
// resync lanes and 7 quotient steps recompute block offsets and output dimensions.
// Reset is synchronous. A stalled result holds the output register; the next voxel is still
// taken meanwhile.
module volume_box_downscale_rgba
   import vbd_pkg::*;
#(
   parameter int MAX_DIM = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [TEXEL_W-1:0]  req_texel,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [TEXEL_W-1:0]  rsp_voxel_out,
   output logic                rsp_last_voxel,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [BIAS_W-1:0]   csr_write_data
);

   cmd_type    cmd;
   status_type status;

   vbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   vbd_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_texel        (req_texel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_voxel_out    (rsp_voxel_out),
      .rsp_last_voxel   (rsp_last_voxel)
   );

   // One item at a time: input is stalled in the cycle after an item is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken in consecutive cycles");

   // A configuration write forces a resync before the next item.
   assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> req_stall)
      else $error("input not stalled after configuration write");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
